// ----- src/pis_pkg.sv -----
`timescale 1ns / 1ps

package pis_pkg;

  localparam int ISLAND_COUNT = 16;

  localparam int WORD_W      = 32;
  localparam int ISLANDS_W   = 16;
  localparam int LIMIT_W     = 19;
  localparam int STATUS_SHIFT = 24;

  localparam logic [LIMIT_W-1:0] POLL_LIMIT_RESET = 19'd500000;

  // item kinds
  localparam logic [1:0] KIND_CMD   = 2'd0;
  localparam logic [1:0] KIND_POLL  = 2'd1;
  localparam logic [1:0] KIND_QUERY = 2'd2;

  // command state types
  localparam logic [1:0] ST_UP         = 2'd0;
  localparam logic [1:0] ST_DOWN       = 2'd1;
  localparam logic [1:0] ST_SOFT_RESET = 2'd2;
  localparam logic [1:0] ST_NONE       = 2'd3;

  localparam logic [1:0] FIELD_ALL = 2'b11;
  localparam logic [1:0] FIELD_SR  = 2'b10;
  localparam logic [1:0] FIELD_OFF = 2'b00;

  // register indexes
  localparam logic REG_POLL_LIMIT = 1'b0;

  typedef struct packed {
    logic [1:0]           kind;
    logic [ISLANDS_W-1:0] islands;
    logic [1:0]           power_op;
    logic                 status_unshifted;
    logic [WORD_W-1:0]    register_word;
  } pis_item_t;

  typedef struct packed {
    logic              write_valid;
    logic [WORD_W-1:0] write_word;
    logic              done_res;
    logic              timed_out;
    logic              rejected;
    logic [1:0]        island_state;
  } pis_result_t;

  // status as seen by a poll or query: raw, or arithmetic shift from bit 24
  function automatic logic [WORD_W-1:0] status_of(input logic [WORD_W-1:0] word,
                                                  input logic unshifted);
    logic [WORD_W-1:0] s;
    begin
      s = unshifted ? word : WORD_W'($signed(word) >>> STATUS_SHIFT);
      return s;
    end
  endfunction

endpackage

// ----- src/pis_cfg_regs.sv -----
`timescale 1ns / 1ps

module pis_cfg_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [2:0]                  cfg_paddr,
  input  logic [31:0]                 cfg_pwdata,
  output logic [31:0]                 cfg_prdata,
  output logic                        cfg_pready,
  output logic [pis_pkg::LIMIT_W-1:0] poll_limit
);
  import pis_pkg::*;

  logic [LIMIT_W-1:0] poll_limit_r;
  logic [LIMIT_W-1:0] poll_limit_nxt;
  logic               reg_idx;
  logic               wr_en;

  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[2];
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    poll_limit_nxt = poll_limit_r;
    if (wr_en && (reg_idx == REG_POLL_LIMIT)) begin
      poll_limit_nxt = cfg_pwdata[LIMIT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poll_limit_r <= POLL_LIMIT_RESET;
    end else begin
      poll_limit_r <= poll_limit_nxt;
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (reg_idx == REG_POLL_LIMIT) begin
      cfg_prdata = {{(32-LIMIT_W){1'b0}}, poll_limit_r};
    end
  end

  assign poll_limit = poll_limit_r;

endmodule

// ----- src/pis_engine.sv -----
`timescale 1ns / 1ps

module pis_engine (
  input  logic                        clk,
  input  logic                        rst_n,
  input  pis_pkg::pis_item_t          item,
  input  logic                        advance,
  input  logic [pis_pkg::LIMIT_W-1:0] poll_limit,
  output pis_pkg::pis_result_t        result
);
  import pis_pkg::*;

  logic               pending_r,    pending_nxt;
  logic [WORD_W-1:0]  expected_r,   expected_nxt;
  logic [WORD_W-1:0]  mask_r,       mask_nxt;
  logic [1:0]         ptype_r,      ptype_nxt;
  logic               punsh_r,      punsh_nxt;
  logic [LIMIT_W-1:0] poll_count_r, poll_count_nxt;

  logic [ISLAND_COUNT-1:0] isl;
  logic [ISLAND_COUNT-1:0] isl_low;
  logic [WORD_W-1:0]       cmd_word;
  logic [WORD_W-1:0]       cmd_mask;
  logic [WORD_W-1:0]       poll_status;
  logic [WORD_W-1:0]       query_status;
  logic [1:0]              query_field;
  logic                    poll_match;

  assign isl     = item.islands[ISLAND_COUNT-1:0];
  assign isl_low = isl & (~isl + ISLAND_COUNT'(1));

  // new control word and compare mask, all fields in parallel
  always_comb begin
    cmd_word = item.register_word;
    cmd_mask = '0;
    for (int i = 0; i < ISLAND_COUNT; i++) begin
      if (isl[i]) begin
        cmd_mask[2*i +: 2] = FIELD_ALL;
        case (item.power_op)
          ST_DOWN:       cmd_word[2*i +: 2] = FIELD_ALL;
          ST_UP:         cmd_word[2*i +: 2] = FIELD_OFF;
          ST_SOFT_RESET: cmd_word[2*i +: 2] = FIELD_SR;
          default:       cmd_word[2*i +: 2] = cmd_word[2*i +: 2];
        endcase
      end
    end
  end

  // lowest selected island picked by a one-hot select
  assign query_status = status_of(item.register_word, item.status_unshifted);
  always_comb begin
    query_field = 2'b00;
    for (int i = 0; i < ISLAND_COUNT; i++) begin
      query_field = query_field | (query_status[2*i +: 2] & {2{isl_low[i]}});
    end
  end

  assign poll_status = status_of(item.register_word, punsh_r);
  assign poll_match  = (ptype_r != ST_NONE) &&
                       ((poll_status & mask_r) == (expected_r & mask_r));

  always_comb begin
    pending_nxt    = pending_r;
    expected_nxt   = expected_r;
    mask_nxt       = mask_r;
    ptype_nxt      = ptype_r;
    punsh_nxt      = punsh_r;
    poll_count_nxt = poll_count_r;
    result         = '0;
    case (item.kind)
      KIND_CMD: begin
        if (pending_r) begin
          result.rejected = 1'b1;
        end else begin
          result.write_valid = 1'b1;
          result.write_word  = cmd_word;
          expected_nxt       = cmd_word;
          mask_nxt           = cmd_mask;
          ptype_nxt          = item.power_op;
          punsh_nxt          = item.status_unshifted;
          poll_count_nxt     = '0;
          pending_nxt        = 1'b1;
        end
      end
      KIND_POLL: begin
        if (pending_r) begin
          if (poll_match) begin
            result.done_res = 1'b1;
            pending_nxt     = 1'b0;
            poll_count_nxt  = '0;
          end else if (poll_count_r >= poll_limit) begin
            result.timed_out = 1'b1;
            pending_nxt      = 1'b0;
            poll_count_nxt   = '0;
          end else begin
            poll_count_nxt = poll_count_r + LIMIT_W'(1);
          end
        end
      end
      KIND_QUERY: begin
        result.island_state = query_field;
      end
      default: begin
        result = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r    <= 1'b0;
      expected_r   <= '0;
      mask_r       <= '0;
      ptype_r      <= ST_UP;
      punsh_r      <= 1'b0;
      poll_count_r <= '0;
    end else if (advance) begin
      pending_r    <= pending_nxt;
      expected_r   <= expected_nxt;
      mask_r       <= mask_nxt;
      ptype_r      <= ptype_nxt;
      punsh_r      <= punsh_nxt;
      poll_count_r <= poll_count_nxt;
    end
  end

endmodule

// ----- src/power_island_command_sequencer.sv -----
`timescale 1ns / 1ps
// An item is taken into the input register and its result into the result register; it
// can transfer out only from there. Throughput: one item per cycle unless stalled; the
// single-pass engine between the two registers sets it. Back-pressure on the result side
// stalls the input register, which stalls in_ready.
// Reset (rst_n, synchronous, active low): both pipeline stages empty, no command
// pending, poll count 0, poll_limit back to 500000.

module power_island_command_sequencer (
  input  logic                          clk,
  input  logic                          rst_n,
  // input channel
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    in_kind,
  input  logic [pis_pkg::ISLANDS_W-1:0] in_islands,
  input  logic [1:0]                    in_power_op,
  input  logic                          in_status_unshifted,
  input  logic [pis_pkg::WORD_W-1:0]    in_register_word,
  // result channel
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_write_valid,
  output logic [pis_pkg::WORD_W-1:0]    out_write_word,
  output logic                          out_done_res,
  output logic                          out_timed_out,
  output logic                          out_rejected,
  output logic [1:0]                    out_island_state,
  // configuration port
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [2:0]                    cfg_paddr,
  input  logic [31:0]                   cfg_pwdata,
  output logic [31:0]                   cfg_prdata,
  output logic                          cfg_pready
);
  import pis_pkg::*;

  // stage 1: input register
  logic        item_vld_r, item_vld_nxt;
  pis_item_t   item_r;
  // stage 2: result register
  logic        res_vld_r, res_vld_nxt;
  pis_result_t res_r;

  pis_result_t        engine_res;
  logic [LIMIT_W-1:0] poll_limit;
  logic               in_xfer;
  logic               advance;
  logic               out_xfer;

  pis_cfg_regs u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready),
    .poll_limit (poll_limit)
  );

  // The engine works on the item in the input register; its state moves
  // only when that item passes into the result register.
  pis_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .item      (item_r),
    .advance   (advance),
    .poll_limit(poll_limit),
    .result    (engine_res)
  );

  // Result register frees up when empty or being taken this cycle.
  assign out_xfer = res_vld_r && out_ready;
  assign advance  = item_vld_r && (!res_vld_r || out_ready);
  // Input register takes a new transfer when empty or moving on.
  assign in_ready = !item_vld_r || advance;
  assign in_xfer  = in_valid && in_ready;

  always_comb begin
    item_vld_nxt = item_vld_r;
    if (in_xfer) begin
      item_vld_nxt = 1'b1;
    end else if (advance) begin
      item_vld_nxt = 1'b0;
    end
    res_vld_nxt = res_vld_r;
    if (advance) begin
      res_vld_nxt = 1'b1;
    end else if (out_xfer) begin
      res_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
      res_vld_r  <= 1'b0;
    end else begin
      item_vld_r <= item_vld_nxt;
      res_vld_r  <= res_vld_nxt;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      item_r.kind             <= in_kind;
      item_r.islands          <= in_islands;
      item_r.power_op         <= in_power_op;
      item_r.status_unshifted <= in_status_unshifted;
      item_r.register_word    <= in_register_word;
    end
    if (advance) begin
      res_r <= engine_res;
    end
  end

  assign out_valid        = res_vld_r;
  assign out_write_valid  = res_r.write_valid;
  assign out_write_word   = res_r.write_word;
  assign out_done_res     = res_r.done_res;
  assign out_timed_out    = res_r.timed_out;
  assign out_rejected     = res_r.rejected;
  assign out_island_state = res_r.island_state;

endmodule

// ----- src/pis_checker.sv -----
`timescale 1ns / 1ps

module pis_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_write_valid,
  input logic [31:0] out_write_word,
  input logic        out_done_res,
  input logic        out_timed_out,
  input logic        out_rejected,
  input logic [1:0]  out_island_state
);

  // a held result keeps its word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_write_word))
    else $error("result changed while stalled");

  // at most one outcome per result
  a_one_outcome: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $onehot0({out_write_valid, out_done_res, out_timed_out, out_rejected}))
    else $error("more than one outcome flagged");

  // no write means a zero word, and a write carries no query answer
  a_word_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_write_valid |-> out_write_word == 32'd0)
    else $error("write word set without write");

  a_write_no_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_write_valid |-> out_island_state == 2'd0)
    else $error("query answer on a command result");

  // empty result stage never blocks input; reset empties the output
  a_ready_when_empty: assert property (@(posedge clk)
    (rst_n && !out_valid |-> in_ready) and (!rst_n |=> !out_valid))
    else $error("input stalled with empty output or output valid after reset");

endmodule

bind power_island_command_sequencer pis_checker u_pis_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_write_valid (out_write_valid),
  .out_write_word  (out_write_word),
  .out_done_res    (out_done_res),
  .out_timed_out   (out_timed_out),
  .out_rejected    (out_rejected),
  .out_island_state(out_island_state)
);

// ----- test/power_island_command_sequencer_tb.sv -----
`timescale 1ns / 1ps

module power_island_command_sequencer_tb;
  import pis_pkg::*;

  // ---------------------------------------------------------------------------
  // Scoreboard: mirrors the sequencer state, predicts one result per input
  // transfer and checks the result channel in order.
  // ---------------------------------------------------------------------------
  class seq_scoreboard;
    logic [LIMIT_W-1:0] limit;
    logic               pending;
    logic [WORD_W-1:0]  exp_word;
    logic [WORD_W-1:0]  cmp_mask;
    logic [1:0]         pend_type;
    logic               pend_unsh;
    logic [LIMIT_W-1:0] poll_count;
    pis_result_t        awaited[$];
    int                 errs;

    function new();
      limit      = POLL_LIMIT_RESET;
      pending    = 1'b0;
      exp_word   = '0;
      cmp_mask   = '0;
      pend_type  = ST_UP;
      pend_unsh  = 1'b0;
      poll_count = '0;
      errs       = 0;
    endfunction

    function void report(string msg);
      errs++;
      $display("MISMATCH: %s", msg);
    endfunction

    // status as the block sees it: raw, or top byte with sign copied upwards
    function logic [WORD_W-1:0] status_word(logic [WORD_W-1:0] w, logic raw);
      return raw ? w : {{24{w[31]}}, w[31:24]};
    endfunction

    function pis_result_t next_result(pis_item_t it);
      pis_result_t       r;
      logic [WORD_W-1:0] w;
      logic [WORD_W-1:0] m;
      logic [WORD_W-1:0] s;
      logic              hit;
      logic              found;
      r = '0;
      case (it.kind)
        KIND_CMD: begin
          if (pending) begin
            r.rejected = 1'b1;
          end else begin
            w = it.register_word;
            m = '0;
            for (int i = 0; i < ISLAND_COUNT; i++) begin
              if (it.islands[i]) begin
                m[2*i +: 2] = FIELD_ALL;
                case (it.power_op)
                  ST_DOWN:       w[2*i +: 2] = FIELD_ALL;
                  ST_UP:         w[2*i +: 2] = FIELD_OFF;
                  ST_SOFT_RESET: w[2*i +: 2] = FIELD_SR;
                  default: ;
                endcase
              end
            end
            r.write_valid = 1'b1;
            r.write_word  = w;
            exp_word      = w;
            cmp_mask      = m;
            pend_type     = it.power_op;
            pend_unsh     = it.status_unshifted;
            poll_count    = '0;
            pending       = 1'b1;
          end
        end
        KIND_POLL: begin
          if (pending) begin
            s   = status_word(it.register_word, pend_unsh);
            hit = (pend_type != ST_NONE) && ((s & cmp_mask) == (exp_word & cmp_mask));
            if (hit) begin
              r.done_res = 1'b1;
              pending    = 1'b0;
              poll_count = '0;
            end else if (poll_count >= limit) begin
              r.timed_out = 1'b1;
              pending     = 1'b0;
              poll_count  = '0;
            end else begin
              poll_count = poll_count + 1'b1;
            end
          end
        end
        KIND_QUERY: begin
          s     = status_word(it.register_word, it.status_unshifted);
          found = 1'b0;
          for (int i = 0; i < ISLAND_COUNT; i++) begin
            if (it.islands[i] && !found) begin
              r.island_state = s[2*i +: 2];
              found          = 1'b1;
            end
          end
        end
        default: ;
      endcase
      return r;
    endfunction

    function void note_input(pis_item_t it);
      awaited.push_back(next_result(it));
    endfunction

    function void check_result(pis_result_t got);
      pis_result_t e;
      if (awaited.size() == 0) begin
        report($sformatf("result with nothing awaited: %h", got));
        return;
      end
      e = awaited.pop_front();
      if (got.write_valid !== e.write_valid)
        report($sformatf("write_valid got %b exp %b", got.write_valid, e.write_valid));
      if (got.write_word !== e.write_word)
        report($sformatf("write_word got %h exp %h", got.write_word, e.write_word));
      if (got.done_res !== e.done_res)
        report($sformatf("done_res got %b exp %b", got.done_res, e.done_res));
      if (got.timed_out !== e.timed_out)
        report($sformatf("timed_out got %b exp %b", got.timed_out, e.timed_out));
      if (got.rejected !== e.rejected)
        report($sformatf("rejected got %b exp %b", got.rejected, e.rejected));
      if (got.island_state !== e.island_state)
        report($sformatf("island_state got %h exp %h", got.island_state, e.island_state));
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // DUT signals
  // ---------------------------------------------------------------------------
  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic [1:0]           in_kind;
  logic [ISLANDS_W-1:0] in_islands;
  logic [1:0]           in_power_op;
  logic                 in_status_unshifted;
  logic [WORD_W-1:0]    in_register_word;
  logic                 out_valid;
  logic                 out_ready;
  logic                 out_write_valid;
  logic [WORD_W-1:0]    out_write_word;
  logic                 out_done_res;
  logic                 out_timed_out;
  logic                 out_rejected;
  logic [1:0]           out_island_state;
  logic                 cfg_psel;
  logic                 cfg_penable;
  logic                 cfg_pwrite;
  logic [2:0]           cfg_paddr;
  logic [31:0]          cfg_pwdata;
  logic [31:0]          cfg_prdata;
  logic                 cfg_pready;

  power_island_command_sequencer uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_kind             (in_kind),
    .in_islands          (in_islands),
    .in_power_op         (in_power_op),
    .in_status_unshifted (in_status_unshifted),
    .in_register_word    (in_register_word),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_write_valid     (out_write_valid),
    .out_write_word      (out_write_word),
    .out_done_res        (out_done_res),
    .out_timed_out       (out_timed_out),
    .out_rejected        (out_rejected),
    .out_island_state    (out_island_state),
    .cfg_psel            (cfg_psel),
    .cfg_penable         (cfg_penable),
    .cfg_pwrite          (cfg_pwrite),
    .cfg_paddr           (cfg_paddr),
    .cfg_pwdata          (cfg_pwdata),
    .cfg_prdata          (cfg_prdata),
    .cfg_pready          (cfg_pready)
  );

  seq_scoreboard sb;

  // sender burst state; no_gaps gives stretches of back-to-back transfers
  int burst_left;
  bit no_gaps;

  // ---------------------------------------------------------------------------
  // Clock, initial drive values and reset
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst_n               = 1'b0;
    in_valid            = 1'b0;
    in_kind             = KIND_CMD;
    in_islands          = '0;
    in_power_op         = ST_UP;
    in_status_unshifted = 1'b0;
    in_register_word    = '0;
    cfg_psel            = 1'b0;
    cfg_penable         = 1'b0;
    cfg_pwrite          = 1'b0;
    cfg_paddr           = '0;
    cfg_pwdata          = '0;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #5000000;
    $display("Regression FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Receiver: its own stall pattern, picking a new mode and period after each run of random length.
  // Mode 0 never stalls, 1 coin toss, 2 periodic stall, 3 mostly stalled.
  // ---------------------------------------------------------------------------
  int rx_mode;
  int rx_left;
  int rx_cyc;
  int rx_period;

  initial begin
    out_ready = 1'b0;
    rx_mode   = 0;
    rx_left   = 0;
    rx_cyc    = 0;
    rx_period = 3;
  end

  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode   = $urandom_range(0, 3);
      rx_left   = $urandom_range(40, 300);
      rx_period = $urandom_range(2, 7);
    end
    rx_left--;
    rx_cyc++;
    case (rx_mode)
      0:       out_ready <= 1'b1;
      1:       out_ready <= $urandom_range(0, 1);
      2:       out_ready <= (rx_cyc % rx_period) != 0;
      default: out_ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  // ---------------------------------------------------------------------------
  // Monitor: both sides sampled at the rising edge, values settled since the
  // falling edge. Result checked before the input note; a transfer in cannot
  // show up at the output in the same cycle anyway.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    pis_item_t   seen;
    pis_result_t got;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        got.write_valid  = out_write_valid;
        got.write_word   = out_write_word;
        got.done_res     = out_done_res;
        got.timed_out    = out_timed_out;
        got.rejected     = out_rejected;
        got.island_state = out_island_state;
        sb.check_result(got);
      end
      if (in_valid && in_ready) begin
        seen.kind             = in_kind;
        seen.islands          = in_islands;
        seen.power_op         = in_power_op;
        seen.status_unshifted = in_status_unshifted;
        seen.register_word    = in_register_word;
        sb.note_input(seen);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic pis_item_t mk_item(logic [1:0] k, logic [ISLANDS_W-1:0] isl,
                                        logic [1:0] typ, logic unsh,
                                        logic [WORD_W-1:0] w);
    pis_item_t it;
    it.kind             = k;
    it.islands          = isl;
    it.power_op         = typ;
    it.status_unshifted = unsh;
    it.register_word    = w;
    return it;
  endfunction

  // Status word for a poll of the pending command. hit: aim for a match
  // (not always reachable through the shifted view); else spoil it.
  function automatic logic [WORD_W-1:0] poll_word(bit hit);
    logic [WORD_W-1:0] w;
    logic [WORD_W-1:0] m;
    logic [WORD_W-1:0] e;
    logic [7:0]        lo;
    int                b;
    m = sb.cmp_mask;
    e = sb.exp_word;
    if (sb.pend_unsh) begin
      w = (e & m) | ($urandom & ~m);
    end else begin
      // shifted view: low byte from bits 31..24, everything above is the sign
      lo = (e[7:0] & m[7:0]) | (8'($urandom) & ~m[7:0]);
      if (!m[7]) lo[7] = (m[31:8] != 0) ? e[8] : lo[7];
      w = {lo, 24'($urandom)};
    end
    if (!hit) begin
      if ($urandom_range(0, 3) == 0) begin
        w = $urandom;
      end else begin
        b    = $urandom_range(0, 31);
        w[b] = ~w[b];
      end
    end
    return w;
  endfunction

  // One input transfer. poll_mode 1/2 fills the word at drive time from the
  // mirrored state (match / spoiled), so it reflects every earlier transfer.
  task automatic send_item(pis_item_t it, int poll_mode);
    int gap;
    if (burst_left == 0) begin
      if (!no_gaps) begin
        gap = $urandom_range(0, 6);
        repeat (gap) begin
          @(negedge clk);
          in_valid <= 1'b0;
        end
      end
      burst_left = $urandom_range(1, 24);
    end
    @(negedge clk);
    if (poll_mode != 0) it.register_word = poll_word(poll_mode == 1);
    in_valid            <= 1'b1;
    in_kind             <= it.kind;
    in_islands          <= it.islands;
    in_power_op         <= it.power_op;
    in_status_unshifted <= it.status_unshifted;
    in_register_word    <= it.register_word;
    burst_left--;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send(logic [1:0] k, logic [ISLANDS_W-1:0] isl, logic [1:0] typ,
                      logic unsh, logic [WORD_W-1:0] w);
    send_item(mk_item(k, isl, typ, unsh, w), 0);
  endtask

  // Drop in_valid and wait until every result has been seen.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // APB write: setup, then access; lands at the edge with pready high.
  task automatic set_poll_limit(logic [LIMIT_W-1:0] val);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {REG_POLL_LIMIT, 2'b00};
    cfg_pwdata  <= 32'(val);
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    sb.limit = val;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  function automatic logic [ISLANDS_W-1:0] rand_islands();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return ISLANDS_W'(1) << $urandom_range(0, ISLANDS_W - 1);
      3:       return ISLANDS_W'($urandom_range(1, 15));
      default: return ISLANDS_W'($urandom);
    endcase
  endfunction

  function automatic pis_item_t rand_cmd();
    pis_item_t it;
    it = mk_item(KIND_CMD, rand_islands(), 2'($urandom_range(0, 3)),
                 1'($urandom_range(0, 1)), $urandom);
    // with a long limit a "none" command would block everything after it
    if (sb.limit > 64 && it.power_op == ST_NONE) it.power_op = 2'($urandom_range(0, 2));
    // shifted status only sees islands 0..3 properly; keep many commands there
    if (!it.status_unshifted && $urandom_range(0, 1)) it.islands &= 16'h000F;
    return it;
  endfunction

  function automatic pis_item_t rand_poll();
    return mk_item(KIND_POLL, ISLANDS_W'($urandom), 2'($urandom_range(0, 3)),
                   1'($urandom_range(0, 1)), '0);
  endfunction

  function automatic pis_item_t rand_query();
    return mk_item(KIND_QUERY, rand_islands(), 2'($urandom_range(0, 3)),
                   1'($urandom_range(0, 1)), $urandom);
  endfunction

  // Mostly well-formed command/poll sequences, with queries, stray
  // commands while busy, idle polls and unused kinds mixed in.
  task automatic run_phase(int n);
    int sent;
    int np;
    int sel;
    sent = 0;
    while (sent < n) begin
      sel = $urandom_range(0, 9);
      if (sel <= 6 || sel == 9) begin
        send_item(rand_cmd(), 0);
        sent++;
        if (sel == 9) begin
          send_item(rand_cmd(), 0);   // arrives while busy
          sent++;
        end
        np = (sb.limit > 8) ? $urandom_range(0, 3) : $urandom_range(0, sb.limit + 2);
        for (int j = 0; j < np; j++) begin
          if ($urandom_range(0, 4) == 0) begin
            send_item(rand_query(), 0);
            sent++;
          end
          send_item(rand_poll(), 2);
          sent++;
        end
        if (sel != 9 && $urandom_range(0, 4) != 0) begin
          send_item(rand_poll(), 1);
          sent++;
        end
      end else if (sel == 7) begin
        send_item(rand_query(), 0);
        sent++;
      end else begin
        if ($urandom_range(0, 1))
          send(2'd3, ISLANDS_W'($urandom), 2'($urandom_range(0, 3)),
               1'($urandom_range(0, 1)), $urandom);
        else
          send_item(rand_poll(), 2);
        sent++;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  logic [LIMIT_W-1:0] limits[8];

  initial begin
    sb         = new();
    burst_left = 0;
    no_gaps    = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset limit still in force: basic up command, miss, match, idle poll
    send(KIND_CMD,   16'h0001, ST_UP,   1'b1, 32'hFFFF_FFFF);
    send(KIND_POLL,  16'h0000, ST_UP,   1'b1, 32'h0000_0001);
    send(KIND_POLL,  16'h0000, ST_UP,   1'b0, 32'hFFFF_FFFC);
    send(KIND_POLL,  16'hFFFF, ST_NONE, 1'b1, 32'hFFFF_FFFF);
    send(2'd3,       16'hFFFF, ST_NONE, 1'b1, 32'hFFFF_FFFF);
    send(KIND_QUERY, 16'h0000, ST_UP,   1'b1, 32'hFFFF_FFFF);
    drain();

    set_poll_limit(19'd1);
    // all islands down, matched through the shifted view of 0xFF000000
    send(KIND_CMD,   16'hFFFF, ST_DOWN, 1'b0, 32'h0000_0000);
    send(KIND_POLL,  16'h0000, ST_UP,   1'b1, 32'hFF00_0000);
    // soft reset, a second command while busy, then two misses: timeout
    send(KIND_CMD,   16'hFFFF, ST_SOFT_RESET, 1'b1, 32'h1234_5678);
    send(KIND_CMD,   16'h00F0, ST_DOWN, 1'b0, 32'h0);
    send(KIND_POLL,  16'h0000, ST_UP,   1'b0, 32'h0000_0000);
    send(KIND_POLL,  16'h0000, ST_UP,   1'b0, 32'h5555_5555);
    // "none" never matches, even with the very word written
    send(KIND_CMD,   16'h8001, ST_NONE, 1'b1, 32'hC000_0003);
    send(KIND_POLL,  16'h0000, ST_UP,   1'b0, 32'hC000_0003);
    send(KIND_POLL,  16'h0000, ST_UP,   1'b0, 32'hC000_0003);
    // no islands selected: empty mask, first poll completes
    send(KIND_CMD,   16'h0000, ST_DOWN, 1'b0, 32'hDEAD_BEEF);
    send(KIND_POLL,  16'hFFFF, ST_NONE, 1'b1, 32'h0123_4567);
    // queries: top island raw, sign-filled island 8, lowest of all shifted
    send(KIND_QUERY, 16'h8000, ST_UP,   1'b1, 32'hC000_0000);
    send(KIND_QUERY, 16'h0100, ST_UP,   1'b0, 32'h8000_0000);
    send(KIND_QUERY, 16'hFFFF, ST_NONE, 1'b0, 32'h0200_0000);
    send(KIND_QUERY, 16'hFFFF, ST_DOWN, 1'b1, 32'h0000_0000);
    send(2'd3,       16'h0000, ST_UP,   1'b0, 32'h0000_0000);
    drain();

    limits = '{19'd1, 19'd2, 19'd3, 19'd524287, 19'd5, 19'd500000, 19'd1,
               19'($urandom_range(2, 12))};
    for (int p = 0; p < 8; p++) begin
      set_poll_limit(limits[p]);
      no_gaps = (p % 3 == 2);
      run_phase(220);
      drain();
    end

    if (sb.awaited.size() != 0)
      sb.report($sformatf("%0d results never arrived", sb.awaited.size()));
    if (sb.errs == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
src/pis_pkg.sv
src/pis_cfg_regs.sv
src/pis_engine.sv
src/power_island_command_sequencer.sv
src/pis_checker.sv
test/power_island_command_sequencer_tb.sv
